### sv/asds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asds_pkg
// Shared types and constants of the additive sine drone synthesizer.
// ----------------------------------------------------------------------------
package asds_pkg;

    localparam int VOICES = 6;
    localparam int LFOS   = 3;

    localparam logic [1:0] REG_MOOD_GOAL    = 2'd0;
    localparam logic [1:0] REG_STEREO_OUT   = 2'd1;
    localparam logic [1:0] REG_INVERSE_RATE = 2'd2;

    localparam logic [24:0] ONE_Q24    = 25'd16777216;
    localparam logic [24:0] BLEND_STEP = 25'd168;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LFO_SIN,
        S_LFO_MUL,
        S_MODS,
        S_V_RATIO,
        S_V_HZ,
        S_V_INC,
        S_V_SIN,
        S_V_AMP,
        S_V_PAN,
        S_FILT,
        S_OUT
    } t_state;

    function automatic logic [18:0] mood_ratio(input logic [1:0] m, input logic [2:0] j);
        logic [18:0] r;
        r = 19'd65536;
        case (m)
            2'd0: begin
                case (j)
                    3'd0: r = 19'd65536;   3'd1: r = 19'd98304;
                    3'd2: r = 19'd131072;  3'd3: r = 19'd196608;
                    3'd4: r = 19'd262144;  default: r = 19'd327680;
                endcase
            end
            2'd1: begin
                case (j)
                    3'd0: r = 19'd65536;   3'd1: r = 19'd69468;
                    3'd2: r = 19'd98304;   3'd3: r = 19'd138936;
                    3'd4: r = 19'd196608;  default: r = 19'd277873;
                endcase
            end
            2'd2: begin
                case (j)
                    3'd0: r = 19'd65536;   3'd1: r = 19'd81920;
                    3'd2: r = 19'd98304;   3'd3: r = 19'd131072;
                    3'd4: r = 19'd163840;  default: r = 19'd196608;
                endcase
            end
            default: begin
                case (j)
                    3'd0: r = 19'd32768;   3'd1: r = 19'd65536;
                    3'd2: r = 19'd98304;   3'd3: r = 19'd131072;
                    3'd4: r = 19'd16384;   default: r = 19'd49152;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [14:0] voice_amp(input logic [2:0] j);
        logic signed [14:0] a;
        case (j)
            3'd0: a = 15'sd8192;   3'd1: a = 15'sd4915;
            3'd2: a = 15'sd3932;   3'd3: a = 15'sd2621;
            3'd4: a = 15'sd1638;   default: a = 15'sd983;
        endcase
        return a;
    endfunction

    // Pan base floor(j*32768/5)-16384 in Q1.15.
    function automatic logic signed [17:0] pan_base(input logic [2:0] j);
        logic signed [17:0] p;
        case (j)
            3'd0: p = -18'sd16384; 3'd1: p = -18'sd9831;
            3'd2: p = -18'sd3277;  3'd3: p = 18'sd3276;
            3'd4: p = 18'sd9830;   default: p = 18'sd16384;
        endcase
        return p;
    endfunction

    function automatic logic [12:0] lfo_rate(input logic [1:0] j);
        logic [12:0] r;
        case (j)
            2'd0: r = 13'd3277;
            2'd1: r = 13'd5243;
            default: r = 13'd1966;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] osc_reset(input logic [2:0] j);
        logic [31:0] p;
        case (j)
            3'd0: p = 32'd0;          3'd1: p = 32'd715827882;
            3'd2: p = 32'd1431655765; 3'd3: p = 32'd2147483648;
            3'd4: p = 32'd2863311530; default: p = 32'd3579139413;
        endcase
        return p;
    endfunction

endpackage

### sv/asds_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asds_if
// Valid/ready channel interfaces for frame requests, samples and config.
// ----------------------------------------------------------------------------
interface asds_req_if;
    logic valid;
    logic ready;
    logic last_frame;
    modport source (output valid, output last_frame, input ready);
    modport sink   (input valid, input last_frame, output ready);
endinterface

interface asds_smp_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [1:0]        current_mood;
    logic              block_end;
    modport source (output valid, output left_sample, output right_sample,
                    output current_mood, output block_end, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input current_mood, input block_end, output ready);
endinterface

interface asds_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/asds_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asds_sine
// Sine lookup: quarter-wave table indexed by the top phase bits, one
// registered read per request.
// ----------------------------------------------------------------------------
module asds_sine
    import asds_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic [31:0]        i_phase,
    output logic signed [16:0] o_sine
);
    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int QW = AW - 2;
    localparam int QD = SINE_TABLE_DEPTH / 4;
    localparam longint PA = 64'd1686629713;
    localparam longint PB = 64'd688904866;
    localparam longint PC = 64'd76016977;

    function automatic logic [16:0] q_entry(input int k);
        longint t, t2, inner, mid, s;
        t = (longint'(k) <<< 30) / QD;
        t2 = (t * t) >>> 30;
        inner = PB - ((PC * t2) >>> 30);
        mid = PA - ((t2 * inner) >>> 30);
        s = (t * mid) >>> 30;
        s = (s + 16384) >>> 15;
        if (s > 32768) s = 32768;
        return 17'(s);
    endfunction

    // Entries for quarter index 0..QD inclusive.
    logic [16:0] c_tab [QD+1];
    for (genvar g = 0; g <= QD; g++) begin : g_tab
        assign c_tab[g] = q_entry(g);
    end

    logic [AW-1:0] w_idx;
    logic [1:0]    w_quad;
    logic [QW-1:0] w_low;
    logic [QW:0]   w_addr;
    logic [16:0]   w_mag;

    assign w_idx  = i_phase[31 -: AW];
    assign w_quad = w_idx[AW-1 -: 2];
    assign w_low  = w_idx[QW-1:0];
    assign w_addr = w_quad[0] ? ((QW+1)'(QD) - {1'b0, w_low}) : {1'b0, w_low};
    assign w_mag  = c_tab[w_addr];

    always_ff @(posedge i_clk) begin
        o_sine <= w_quad[1] ? -$signed(w_mag) : $signed(w_mag);
    end
endmodule

### sv/additive_sine_drone_synth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_sine_drone_synth
// Additive drone: three sine LFOs modulate six sine voices, one frame per item.
// ----------------------------------------------------------------------------
// Use: each item on the request channel asks for one stereo frame; the
// result item carries left/right samples (Q1.15), the mood in effect and a
// copy of last_frame. Configuration writes (target mood, stereo/mono,
// inverse rate) go on the config channel while the block is idle.
// Sequence: each frame runs two LFO steps (sine read, multiply) per LFO,
// a modulation step, six voice steps (ratio, frequency, increment, sine,
// amplitude, pan) per voice, then filter and output steps; one shared
// multiplier serves the LFO multiply and the voice frequency, increment and
// sine steps; requests are taken only in idle, reached as the result loads.
// Reset: synchronous, active low; state, phase, filter, mood and config regs
// return to reset values (phases spread, filter zero, mood neutral, stereo on).
// Stall: the result holds in its output register until taken; one more
// request is still accepted and computed, and the block then waits in its
// output step, with the request channel not ready, until the held item goes.
// ----------------------------------------------------------------------------
module additive_sine_drone_synth
    import asds_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asds_req_if.sink    req,
    asds_smp_if.source  smp,
    asds_cfg_if.sink    cfg
);
    t_state r_state, n_state;
    logic [2:0]  r_j;
    logic [31:0] r_osc [VOICES];
    logic [31:0] r_mod [LFOS];
    logic signed [16:0] r_lv [LFOS];
    logic signed [23:0] r_lpl, r_lpr;
    logic [1:0]  r_mood, r_target;
    logic [24:0] r_blend;
    logic        r_stereo;
    logic [31:0] r_inv;
    logic        r_last;
    // working registers
    logic [63:0] r_acc;
    logic signed [17:0] r_fm, r_amd, r_psh;
    logic signed [37:0] r_m;
    logic signed [40:0] r_sl, r_sr;
    logic signed [15:0] r_ol, r_or;
    logic        r_vld;

    logic [31:0] w_phase;
    logic signed [16:0] w_sine;

    asds_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
        .i_clk(i_clk), .i_phase(w_phase), .o_sine(w_sine)
    );

    assign w_phase = (r_state == S_LFO_SIN) ? r_mod[r_j[1:0]] : r_osc[r_j];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (req.valid && !cfg.valid) n_state = S_LFO_SIN;
            S_LFO_SIN: n_state = S_LFO_MUL;
            S_LFO_MUL: n_state = (r_j == 3'd2) ? S_MODS : S_LFO_SIN;
            S_MODS:    n_state = S_V_RATIO;
            S_V_RATIO: n_state = S_V_HZ;
            S_V_HZ:    n_state = S_V_INC;
            S_V_INC:   n_state = S_V_SIN;
            S_V_SIN:   n_state = S_V_AMP;
            S_V_AMP:   n_state = S_V_PAN;
            S_V_PAN:   n_state = (r_j == 3'd5) ? S_FILT : S_V_RATIO;
            S_FILT:    n_state = S_OUT;
            S_OUT:     if (!r_vld || smp.ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // A configuration write takes precedence over a request in the same cycle.
    always_comb begin
        req.ready = (r_state == S_IDLE) && !cfg.valid;
        cfg.ready = (r_state == S_IDLE);
    end

    // Shared multiplier operands.
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic signed [18:0] w_pan, w_panc;
    logic signed [19:0] w_am;
    logic [18:0] w_cur, w_tgt;
    logic signed [24:0] w_fl, w_fr;
    logic signed [24:0] w_mono;

    assign w_pan  = 19'(r_psh) + 19'(pan_base(r_j));
    assign w_panc = (w_pan > 19'sd32768) ? 19'sd32768 :
                    (w_pan < -19'sd32768) ? -19'sd32768 : w_pan;
    assign w_am   = r_j[0] ? (20'sd32768 - 20'(r_amd)) : (20'sd32768 + 20'(r_amd));
    assign w_cur  = mood_ratio(r_mood, r_j);
    assign w_tgt  = mood_ratio(r_target, r_j);

    // The sine read in S_V_SIN was taken from the phase before its update.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_LFO_MUL: begin w_ma = {2'b0, r_inv}; w_mb = 34'(lfo_rate(r_j[1:0])); end
            S_V_HZ:    begin w_ma = 34'(r_acc[24:0]); w_mb = 34'(r_fm); end
            S_V_INC:   begin w_ma = 34'(r_acc[33:0]); w_mb = {2'b0, r_inv}; end
            S_V_SIN:   begin w_ma = 34'(w_sine); w_mb = 34'(voice_amp(r_j)); end
            default:   begin w_ma = '0; w_mb = '0; end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
        if (x > 48'sd8388607) return 24'sd8388607;
        if (x < -48'sd8388608) return -24'sd8388608;
        return x[23:0];
    endfunction
    function automatic logic signed [15:0] sat16(input logic signed [24:0] x);
        if (x > 25'sd32767) return 16'sd32767;
        if (x < -25'sd32768) return -16'sd32768;
        return x[15:0];
    endfunction

    logic signed [47:0] w_nl, w_nr;
    logic signed [40:0] w_xl, w_xr;
    assign w_xl = r_sl >>> 7;
    assign w_xr = r_sr >>> 7;
    assign w_nl = (48'(r_lpl) * 48'sd31130 + 48'(w_xl) * 48'sd1638) >>> 15;
    assign w_nr = (48'(r_lpr) * 48'sd31130 + 48'(w_xr) * 48'sd1638) >>> 15;
    assign w_fl = 25'(r_lpl);
    assign w_fr = 25'(r_lpr);
    assign w_mono = (w_fl + w_fr) >>> 9;

    // Ratio crossfade in Q16, result before >>24.
    logic [43:0] w_mix;
    assign w_mix = 44'(w_cur) * 44'(ONE_Q24 - r_blend) + 44'(w_tgt) * 44'(r_blend);

    logic signed [58:0] w_vm;
    logic signed [38:0] w_mp;
    assign w_vm = 59'(r_m) * 59'(w_am);
    assign w_mp = 39'(w_vm >>> 15);

    logic signed [58:0] w_pl, w_pr;
    logic [24:0] w_bn;
    assign w_bn = r_blend + BLEND_STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_j      <= '0;
            r_vld    <= 1'b0;
            r_lpl    <= '0;
            r_lpr    <= '0;
            r_mood   <= '0;
            r_target <= '0;
            r_blend  <= '0;
            r_stereo <= 1'b1;
            r_inv    <= 32'd97391;
            r_mod[0] <= 32'd0;
            r_mod[1] <= 32'd1417339208;
            r_mod[2] <= 32'd2834678415;
            for (int k = 0; k < VOICES; k++) r_osc[k] <= osc_reset(3'(k));
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_vld || smp.ready)) r_vld <= 1'b1;
            else if (smp.ready) r_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (cfg.valid) begin
                        case (cfg.index)
                            REG_MOOD_GOAL: begin
                                if (cfg.data[1:0] != r_mood && cfg.data[1:0] != r_target) begin
                                    r_target <= cfg.data[1:0];
                                    r_blend  <= '0;
                                end
                            end
                            REG_STEREO_OUT:   r_stereo <= cfg.data[0];
                            REG_INVERSE_RATE: r_inv <= cfg.data;
                            default: ;
                        endcase
                    end else if (req.valid) begin
                        r_last <= req.last_frame;
                        r_j    <= '0;
                        r_sl   <= '0;
                        r_sr   <= '0;
                    end
                end
                S_LFO_MUL: begin
                    r_lv[r_j[1:0]]  <= w_sine;
                    r_mod[r_j[1:0]] <= r_mod[r_j[1:0]] + w_prod[47:16];
                    r_j <= (r_j == 3'd2) ? 3'd0 : r_j + 3'd1;
                end
                S_MODS: begin
                    r_fm  <= 18'sd32768 + 18'((35'(r_lv[0]) * 35'sd655) >>> 15);
                    r_amd <= 18'((35'(r_lv[1]) * 35'sd3277) >>> 15);
                    r_psh <= 18'((35'(r_lv[2]) * 35'sd3277) >>> 15);
                end
                S_V_RATIO: r_acc <= 64'(w_mix >> 24) * 64'd55;
                S_V_HZ:    r_acc <= 64'(w_prod >>> 15);
                S_V_INC:   r_osc[r_j] <= r_osc[r_j] + w_prod[47:16];
                S_V_SIN:   r_m <= w_prod[37:0];
                S_V_AMP:   r_m <= 38'(w_mp);
                S_V_PAN: begin
                    r_sl <= r_sl + 41'(w_pl >>> 16);
                    r_sr <= r_sr + 41'(w_pr >>> 16);
                    r_j  <= (r_j == 3'd5) ? 3'd0 : r_j + 3'd1;
                end
                S_FILT: begin
                    r_lpl <= sat24(w_nl);
                    r_lpr <= sat24(w_nr);
                    if (r_mood != r_target) begin
                        if (w_bn >= ONE_Q24) begin
                            r_blend <= '0;
                            r_mood  <= r_target;
                        end else begin
                            r_blend <= w_bn;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_vld || smp.ready) begin
                        r_ol  <= r_stereo ? sat16(w_fl >>> 8) : sat16(w_mono);
                        r_or  <= r_stereo ? sat16(w_fr >>> 8) : sat16(w_mono);
                    end
                end
                default: ;
            endcase
        end
    end

    // Voice already scaled by amplitude modulation, now panned.
    assign w_pl = 59'(r_m) * 59'(20'sd32768 - 20'(w_panc));
    assign w_pr = 59'(r_m) * 59'(20'sd32768 + 20'(w_panc));

    logic [1:0] r_omood;
    logic       r_oend;
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_vld || smp.ready)) begin
            r_omood <= r_mood;
            r_oend  <= r_last;
        end
    end

    assign smp.valid        = r_vld;
    assign smp.left_sample  = r_ol;
    assign smp.right_sample = r_or;
    assign smp.current_mood = r_omood;
    assign smp.block_end    = r_oend;

`ifndef SYNTHESIS
    a_no_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !req.ready)
        else $error("request ready while busy");
    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blend < ONE_Q24)
        else $error("blend out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !smp.ready) |=> $stable(r_ol) && $stable(r_or))
        else $error("stalled sample changed");
`endif
endmodule
